// ===== design/tae_pkg.sv =====
// Package for the Thumb ALU execute stage: operand and result types and opcode names.
// It has no dependencies. The datapath and the top level use it by scoped names.
package tae_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned InstrW = 16;
    localparam int unsigned FlagW  = 4;
    localparam int unsigned RegW   = 3;
    localparam int unsigned InDataW  = 120;
    localparam int unsigned OutDataW = 48;

    // Positions of the flags in the NZCV nibble.
    localparam int unsigned FlagN = 3;
    localparam int unsigned FlagZ = 2;
    localparam int unsigned FlagC = 1;
    localparam int unsigned FlagV = 0;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } tae_shift_t;

    typedef enum logic [1:0] {
        IMM_MOV = 2'd0,
        IMM_CMP = 2'd1,
        IMM_ADD = 2'd2,
        IMM_SUB = 2'd3
    } tae_imm_op_t;

    typedef enum logic [3:0] {
        ALU_AND = 4'd0,
        ALU_EOR = 4'd1,
        ALU_LSL = 4'd2,
        ALU_LSR = 4'd3,
        ALU_ASR = 4'd4,
        ALU_ADC = 4'd5,
        ALU_SBC = 4'd6,
        ALU_ROR = 4'd7,
        ALU_TST = 4'd8,
        ALU_NEG = 4'd9,
        ALU_CMP = 4'd10,
        ALU_CMN = 4'd11,
        ALU_ORR = 4'd12,
        ALU_MUL = 4'd13,
        ALU_BIC = 4'd14,
        ALU_MVN = 4'd15
    } tae_alu_op_t;

    typedef struct packed {
        logic [InstrW-1:0] instr_word;
        logic [WordW-1:0]  dest_value;
        logic [WordW-1:0]  source_value;
        logic [WordW-1:0]  third_value;
        logic [FlagW-1:0]  flags_in;
    } tae_item_t;

    typedef struct packed {
        logic [WordW-1:0] result_value;
        logic [RegW-1:0]  dest_index;
        logic             write_enable;
        logic [FlagW-1:0] flags_out;
        logic             illegal;
    } tae_result_t;

endpackage

// ===== design/tae_exec.sv =====
// Combinational datapath of the Thumb ALU execute stage: decode, shifter, adder, multiplier.
// Depends on tae_pkg for the item and result types and the opcode names.
module tae_exec
(
    input  tae_pkg::tae_item_t   item,
    output tae_pkg::tae_result_t res
);

    logic [15:0] ins;
    logic [31:0] dv;
    logic [31:0] sv;
    logic [31:0] tv;
    logic [3:0]  fin;

    logic is_f1;
    logic is_f2;
    logic is_f3;
    logic is_f4;

    tae_pkg::tae_alu_op_t alu_op;
    tae_pkg::tae_imm_op_t imm_op;
    logic [31:0] imm8;
    logic [31:0] imm3;

    // shifter
    tae_pkg::tae_shift_t sh_kind;
    logic [31:0] sh_v;
    logic [7:0]  sh_amt;
    logic [31:0] sh_res;
    logic        sh_c;
    logic [32:0] lsl_wide;
    logic [32:0] rsh_wide;
    logic [32:0] asr_wide;
    logic [63:0] ror_wide;

    // adder
    logic [31:0] add_a;
    logic [31:0] add_b;
    logic        add_cin;
    logic [32:0] add_sum;
    logic [3:0]  add_flags;

    logic [31:0] mul_lo;
    logic [3:0]  logic_flags;
    logic [31:0] logic_res;

    logic [31:0] rv;
    logic [2:0]  rd;
    logic        we;
    logic [3:0]  fo;
    logic        ill;

    assign ins = item.instr_word;
    assign dv  = item.dest_value;
    assign sv  = item.source_value;
    assign tv  = item.third_value;
    assign fin = item.flags_in;

    assign is_f1 = (ins[15:13] == 3'b000) && (ins[12:11] != 2'b11);
    assign is_f2 = (ins[15:11] == 5'b00011);
    assign is_f3 = (ins[15:13] == 3'b001);
    assign is_f4 = (ins[15:10] == 6'b010000);

    assign alu_op = tae_pkg::tae_alu_op_t'(ins[9:6]);
    assign imm_op = tae_pkg::tae_imm_op_t'(ins[12:11]);
    assign imm8   = {24'd0, ins[7:0]};
    assign imm3   = {29'd0, ins[8:6]};

    // Shifter operand selection: immediate shifts act on Rs, register shifts on Rd.
    always_comb
    begin
        sh_kind = tae_pkg::SH_LSL;
        sh_v    = dv;
        sh_amt  = sv[7:0];
        if (is_f1)
        begin
            sh_kind = tae_pkg::tae_shift_t'(ins[12:11]);
            sh_v    = sv;
            // LSR and ASR by an immediate of zero mean a shift by 32
            if ((sh_kind != tae_pkg::SH_LSL) && (ins[10:6] == 5'd0))
                sh_amt = 8'd32;
            else
                sh_amt = {3'd0, ins[10:6]};
        end
        else
        begin
            case (alu_op)
                tae_pkg::ALU_LSR: sh_kind = tae_pkg::SH_LSR;
                tae_pkg::ALU_ASR: sh_kind = tae_pkg::SH_ASR;
                tae_pkg::ALU_ROR: sh_kind = tae_pkg::SH_ROR;
                default:          sh_kind = tae_pkg::SH_LSL;
            endcase
        end
    end

    assign lsl_wide = {1'b0, sh_v} << sh_amt[4:0];
    assign rsh_wide = {sh_v, 1'b0} >> sh_amt[4:0];
    assign asr_wide = 33'($signed({sh_v, 1'b0}) >>> sh_amt[4:0]);
    assign ror_wide = {sh_v, sh_v} >> sh_amt[4:0];

    always_comb
    begin
        sh_res = sh_v;
        sh_c   = fin[tae_pkg::FlagC];
        if (sh_amt != 8'd0)
        begin
            case (sh_kind)
                tae_pkg::SH_LSL:
                begin
                    if (sh_amt < 8'd32)
                    begin
                        sh_res = lsl_wide[31:0];
                        sh_c   = lsl_wide[32];
                    end
                    else
                    begin
                        sh_res = 32'd0;
                        sh_c   = (sh_amt == 8'd32) ? sh_v[0] : 1'b0;
                    end
                end
                tae_pkg::SH_LSR:
                begin
                    if (sh_amt < 8'd32)
                    begin
                        sh_res = rsh_wide[32:1];
                        sh_c   = rsh_wide[0];
                    end
                    else
                    begin
                        sh_res = 32'd0;
                        sh_c   = (sh_amt == 8'd32) ? sh_v[31] : 1'b0;
                    end
                end
                tae_pkg::SH_ASR:
                begin
                    if (sh_amt < 8'd32)
                    begin
                        sh_res = asr_wide[32:1];
                        sh_c   = asr_wide[0];
                    end
                    else
                    begin
                        sh_res = {32{sh_v[31]}};
                        sh_c   = sh_v[31];
                    end
                end
                default:
                begin
                    // a rotate by a multiple of 32 keeps the value; C takes bit 31 either way
                    sh_res = ror_wide[31:0];
                    sh_c   = ror_wide[31];
                end
            endcase
        end
    end

    // One shared adder; subtraction is a + ~b + 1, and SBC is a + ~b + C.
    always_comb
    begin
        add_a   = dv;
        add_b   = sv;
        add_cin = 1'b0;
        if (is_f2)
        begin
            add_a   = sv;
            add_b   = ins[10] ? imm3 : tv;
            add_cin = ins[9];
            if (ins[9])
                add_b = ~add_b;
        end
        else if (is_f3)
        begin
            add_b = imm8;
            if ((imm_op == tae_pkg::IMM_CMP) || (imm_op == tae_pkg::IMM_SUB))
            begin
                add_b   = ~imm8;
                add_cin = 1'b1;
            end
        end
        else
        begin
            case (alu_op)
                tae_pkg::ALU_ADC: add_cin = fin[tae_pkg::FlagC];
                tae_pkg::ALU_SBC:
                begin
                    add_b   = ~sv;
                    add_cin = fin[tae_pkg::FlagC];
                end
                tae_pkg::ALU_NEG:
                begin
                    add_a   = 32'd0;
                    add_b   = ~sv;
                    add_cin = 1'b1;
                end
                tae_pkg::ALU_CMP:
                begin
                    add_b   = ~sv;
                    add_cin = 1'b1;
                end
                default:
                begin
                    add_b   = sv;
                    add_cin = 1'b0;
                end
            endcase
        end
    end

    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};
    assign add_flags = {add_sum[31], (add_sum[31:0] == 32'd0), add_sum[32],
                        ((add_a[31] ^ add_sum[31]) & (add_b[31] ^ add_sum[31]))};

    assign mul_lo = dv * sv;

    // Logical, shift, move and multiply results: N and Z from the value, V held.
    always_comb
    begin
        logic_res = sh_res;
        if (is_f3)
            logic_res = imm8;
        else if (is_f4)
        begin
            case (alu_op)
                tae_pkg::ALU_AND: logic_res = dv & sv;
                tae_pkg::ALU_TST: logic_res = dv & sv;
                tae_pkg::ALU_EOR: logic_res = dv ^ sv;
                tae_pkg::ALU_ORR: logic_res = dv | sv;
                tae_pkg::ALU_MUL: logic_res = mul_lo;
                tae_pkg::ALU_BIC: logic_res = dv & ~sv;
                tae_pkg::ALU_MVN: logic_res = ~sv;
                default:          logic_res = sh_res;
            endcase
        end
        logic_flags = fin;
        logic_flags[tae_pkg::FlagN] = logic_res[31];
        logic_flags[tae_pkg::FlagZ] = (logic_res == 32'd0);
        // sh_c already equals the incoming C when no shift is under way
        if (is_f1 || (is_f4 && ((alu_op == tae_pkg::ALU_LSL) || (alu_op == tae_pkg::ALU_LSR)
                || (alu_op == tae_pkg::ALU_ASR) || (alu_op == tae_pkg::ALU_ROR))))
            logic_flags[tae_pkg::FlagC] = sh_c;
    end

    always_comb
    begin
        rv  = 32'd0;
        rd  = 3'd0;
        we  = 1'b0;
        fo  = fin;
        ill = 1'b0;
        if (is_f1)
        begin
            rd = ins[2:0];
            we = 1'b1;
            rv = logic_res;
            fo = logic_flags;
        end
        else if (is_f2)
        begin
            rd = ins[2:0];
            we = 1'b1;
            rv = add_sum[31:0];
            fo = add_flags;
        end
        else if (is_f3)
        begin
            rd = ins[10:8];
            case (imm_op)
                tae_pkg::IMM_MOV:
                begin
                    we = 1'b1;
                    rv = logic_res;
                    fo = logic_flags;
                end
                tae_pkg::IMM_CMP: fo = add_flags;
                default:
                begin
                    we = 1'b1;
                    rv = add_sum[31:0];
                    fo = add_flags;
                end
            endcase
        end
        else if (is_f4)
        begin
            rd = ins[2:0];
            case (alu_op)
                tae_pkg::ALU_ADC, tae_pkg::ALU_SBC, tae_pkg::ALU_NEG:
                begin
                    we = 1'b1;
                    rv = add_sum[31:0];
                    fo = add_flags;
                end
                tae_pkg::ALU_CMP, tae_pkg::ALU_CMN: fo = add_flags;
                tae_pkg::ALU_TST:                   fo = logic_flags;
                default:
                begin
                    we = 1'b1;
                    rv = logic_res;
                    fo = logic_flags;
                end
            endcase
        end
        else
        begin
            ill = 1'b1;
        end
    end

    assign res.result_value = rv;
    assign res.dest_index   = rd;
    assign res.write_enable = we;
    assign res.flags_out    = fo;
    assign res.illegal      = ill;

endmodule

// ===== design/thumb_alu_execute.sv =====
// Top level of the Thumb ALU execute stage: input register, datapath, result register.
// Depends on tae_pkg and tae_exec.
//
// Usage:
//   s_axis carries one instruction per transaction: the Thumb halfword, the values of
//   Rd, Rs/Rb and Rn and the incoming NZCV flags. m_axis returns one result per
//   instruction: the value, the destination register, its write enable, the new flags
//   and a mark for halfwords outside formats 1 to 4.
//   An accepted transaction lands in the input register; the datapath (shifter, one
//   adder, a 32x32 multiplier) then fills the result register once that register is free,
//   and m_axis_tvalid rises with it. A new instruction is taken every cycle while the
//   receiver does not stall; the single pass through the multiplier sets the cycle time.
//   Reset empties both stages and holds s_axis_tready high.
//   When the receiver stalls, the result register holds; the input register still
//   takes one more transaction, after which s_axis_tready falls until m_axis_tready
//   returns. Results leave in the order their instructions arrived.
module thumb_alu_execute
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [15:0] instr_word, [47:16] dest_value, [79:48] source_value,
    // [111:80] third_value, [115:112] flags_in, [119:116] zero
    input  logic [tae_pkg::InDataW-1:0]    s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] result_value, [34:32] dest_index, [35] write_enable,
    // [39:36] flags_out, [40] illegal, [47:41] zero
    output logic [tae_pkg::OutDataW-1:0]   m_axis_tdata
);

    logic                 in_valid_reg;
    logic                 in_valid_next;
    tae_pkg::tae_item_t   in_item_reg;
    tae_pkg::tae_item_t   in_item_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    tae_pkg::tae_result_t out_res_reg;
    tae_pkg::tae_result_t out_res_next;
    logic                 out_load;
    logic                 in_load;

    assign out_load      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    assign in_item_next.instr_word   = s_axis_tdata[15:0];
    assign in_item_next.dest_value   = s_axis_tdata[47:16];
    assign in_item_next.source_value = s_axis_tdata[79:48];
    assign in_item_next.third_value  = s_axis_tdata[111:80];
    assign in_item_next.flags_in     = s_axis_tdata[115:112];

    tae_exec u_exec
    (
        .item (in_item_reg),
        .res  (out_res_next)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = in_valid_reg;
            in_valid_next  = 1'b0;
        end
        if (in_load)
            in_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
            in_item_reg <= in_item_next;
        if (out_load && in_valid_reg)
            out_res_reg <= out_res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_res_reg.illegal, out_res_reg.flags_out,
                            out_res_reg.write_enable, out_res_reg.dest_index,
                            out_res_reg.result_value};

`ifndef SYNTH
    a_ill_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.illegal) |-> !out_res_reg.write_enable)
        else $error("illegal instruction produced a register write");

    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_res_reg.write_enable) |-> (out_res_reg.result_value == 32'd0))
        else $error("result value not cleared without write enable");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while both stages are full and stalled");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> in_valid_reg)
        else $error("accepted transaction lost from the input register");
`endif

endmodule
